>>> rtl/lru_page_cache_directory_unit_assert.svh
// assertion macros shared by the directory unit
`ifndef LRU_PAGE_CACHE_DIRECTORY_UNIT_ASSERT_SVH
`define LRU_PAGE_CACHE_DIRECTORY_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LPCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpcd_pkg.sv
package lpcd_pkg;

    localparam int DEF_ENTRIES  = 8;
    localparam int DEF_CAPACITY = 2;
    localparam int PAGE_W       = 32;
    localparam int STAMP_W      = 32;
    localparam int CAP_W        = 4;
    localparam int SLOT_W       = 3;
    localparam int OCC_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [STAMP_W-1:0] STAMP_INIT = 32'd1;

    typedef enum logic [1:0] {
        REQ_LOOKUP,
        REQ_INSERT,
        REQ_INVALID
    } t_req_class;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 2'd0,
        ST_LOADED  = 2'd1,
        ST_FAILED  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_SHIFT,
        BK_APPEND,
        BK_RESULT
    } t_back_state;

    typedef struct packed {
        t_req_class        cls;
        logic [PAGE_W-1:0] page;
        logic              ok;
    } t_req;

endpackage

>>> rtl/lru_page_cache_directory_unit.sv
// Directory of a small fully associative page cache with least-recently-used
// eviction by access stamp. Each input transfer is a lookup or an insert of a
// 32-bit page id and yields one result transfer. A two-entry queue sits behind
// the input, so up to two requests are taken while one is being worked on, and
// a finished result waits in an output register. Work on a request is set by
// the single read port of the entry memory, which is scanned one entry per
// cycle. An eviction also moves the entries above the victim down by one, and a
// lookup of id 0 skips the scan. A result that is not taken holds the back end,
// and the queue then fills and stalls the input. No clearing pass is needed
// after reset. The capacity register may be written only while no request is
// in flight.
`include "lru_page_cache_directory_unit_assert.svh"

module lru_page_cache_directory_unit #(
    parameter int ENTRIES = lpcd_pkg::DEF_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpcd_pkg::CAP_W-1:0]          i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // page_id [31:0], fetch_ok [32], zero pad [39:33]
    input  logic [lpcd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // kind [0]
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // slot [2:0], evicted [3], evicted_page [35:4], occupancy [39:36]
    output logic [lpcd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [lpcd_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    logic           req_valid;
    logic           req_ready;
    lpcd_pkg::t_req req;

    lpcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    lpcd_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

    `LPCD_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, req_valid, "accepted transfer not queued")
    `LPCD_ASSERT_NOW(a_invalid_class, i_clk, i_rst_n, req_valid && req.cls == lpcd_pkg::REQ_INVALID, req.page == '0, "invalid class with nonzero page")
    `LPCD_ASSERT_NOW(a_evict_loaded, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[3], o_m_axis_tuser == lpcd_pkg::ST_LOADED, "eviction without append")
    `LPCD_ASSERT_NOW(a_nochange_clean, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == lpcd_pkg::ST_FAILED || o_m_axis_tuser == lpcd_pkg::ST_INVALID), o_m_axis_tdata[35:0] == '0, "failed result carries slot or eviction")

endmodule

>>> rtl/lpcd_front.sv
module lpcd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lpcd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_req_valid,
    output lpcd_pkg::t_req                      o_req,
    input  logic                                i_req_ready
);

    localparam int QPTR_W = $clog2(lpcd_pkg::QUEUE_DEPTH);

    lpcd_pkg::t_req   r_q [lpcd_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_fill;
    lpcd_pkg::t_req    in_req;
    logic              push;
    logic              pop;

    // classify the incoming transfer
    always_comb begin
        in_req.page = i_s_tdata[lpcd_pkg::PAGE_W-1:0];
        in_req.ok   = i_s_tdata[lpcd_pkg::PAGE_W];
        if (i_s_tuser) begin
            in_req.cls = lpcd_pkg::REQ_INSERT;
        end else if (in_req.page == '0) begin
            in_req.cls = lpcd_pkg::REQ_INVALID;
        end else begin
            in_req.cls = lpcd_pkg::REQ_LOOKUP;
        end
    end

    assign o_s_tready  = (r_fill != (QPTR_W+1)'(lpcd_pkg::QUEUE_DEPTH));
    assign o_req_valid = (r_fill != '0);
    assign o_req       = r_q[r_rd_ptr];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_req_valid && i_req_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_req;
        end
    end

endmodule

>>> rtl/lpcd_back.sv
module lpcd_back #(
    parameter int ENTRIES = lpcd_pkg::DEF_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpcd_pkg::CAP_W-1:0]          i_cfg_wdata,
    input  logic                                i_req_valid,
    input  lpcd_pkg::t_req                      i_req,
    output logic                                o_req_ready,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lpcd_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [lpcd_pkg::STATUS_W-1:0]       o_m_tuser
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CW      = (CNT_W > lpcd_pkg::CAP_W) ? CNT_W : lpcd_pkg::CAP_W;
    localparam int DEF_EFF = (lpcd_pkg::DEF_CAPACITY > ENTRIES) ? ENTRIES
                                                                : lpcd_pkg::DEF_CAPACITY;
    localparam int PW      = lpcd_pkg::PAGE_W;
    localparam int SW      = lpcd_pkg::STAMP_W;

    logic [PW-1:0] mem_page  [ENTRIES];
    logic [SW-1:0] mem_stamp [ENTRIES];

    lpcd_pkg::t_back_state r_state, n_state;
    lpcd_pkg::t_req        r_req, n_req;
    lpcd_pkg::t_status     r_res_status, n_res_status;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SW-1:0]         r_stamp, n_stamp;
    logic [lpcd_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]      r_iss, n_iss;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]      r_vict_idx, n_vict_idx;
    logic [SW-1:0]         r_best, n_best;
    logic [PW-1:0]         r_vict_page, n_vict_page;
    logic [IDX_W-1:0]      r_res_slot, n_res_slot;
    logic                  r_res_evicted, n_res_evicted;
    logic [PW-1:0]         r_res_evp, n_res_evp;
    logic                  r_out_valid, n_out_valid;
    logic [lpcd_pkg::OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [lpcd_pkg::STATUS_W-1:0]    r_out_tuser, n_out_tuser;
    logic [PW-1:0]         r_rd_page;
    logic [SW-1:0]         r_rd_stamp;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [PW-1:0]         wr_page;
    logic [SW-1:0]         wr_stamp;
    logic [CW-1:0]         cap_ext;
    logic [CW-1:0]         count_ext;
    logic [CW-1:0]         cap_eff;
    logic                  full;
    logic [IDX_W+lpcd_pkg::SLOT_W-1:0] slot_ext;
    logic [CNT_W+lpcd_pkg::OCC_W-1:0]  occ_ext;

    assign o_req_ready = (r_state == lpcd_pkg::BK_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_tdata;
    assign o_m_tuser   = r_out_tuser;

    // effective capacity: zero means default, clipped to table depth
    always_comb begin
        cap_ext   = CW'(r_cap);
        count_ext = CW'(r_count);
        if (r_cap == '0) begin
            cap_eff = CW'(DEF_EFF);
        end else if (cap_ext > CW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
        full = (count_ext >= cap_eff) && (r_count != '0);
    end

    assign slot_ext = {{lpcd_pkg::SLOT_W{1'b0}}, r_res_slot};
    assign occ_ext  = {{lpcd_pkg::OCC_W{1'b0}}, r_count};

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_count       = r_count;
        n_stamp       = r_stamp;
        n_iss         = r_iss;
        n_pend        = 1'b0;
        n_pidx        = r_pidx;
        n_found       = r_found;
        n_hit_idx     = r_hit_idx;
        n_vict_idx    = r_vict_idx;
        n_best        = r_best;
        n_vict_page   = r_vict_page;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_res_evicted = r_res_evicted;
        n_res_evp     = r_res_evp;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_tdata   = r_out_tdata;
        n_out_tuser   = r_out_tuser;
        rd_en         = 1'b0;
        rd_addr       = r_iss[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = r_count[IDX_W-1:0];
        wr_page       = r_req.page;
        wr_stamp      = r_stamp;

        case (r_state)
            lpcd_pkg::BK_IDLE: begin
                if (i_req_valid) begin
                    n_req         = i_req;
                    n_iss         = '0;
                    n_found       = 1'b0;
                    n_res_slot    = '0;
                    n_res_evicted = 1'b0;
                    n_res_evp     = '0;
                    if (i_req.cls == lpcd_pkg::REQ_INVALID) begin
                        n_res_status = lpcd_pkg::ST_INVALID;
                        n_state      = lpcd_pkg::BK_RESULT;
                    end else begin
                        n_state = lpcd_pkg::BK_SCAN;
                    end
                end
            end
            lpcd_pkg::BK_SCAN: begin
                // one entry read per cycle, compared in the next cycle
                rd_en  = (r_iss < r_count);
                n_pend = rd_en;
                n_pidx = r_iss[IDX_W-1:0];
                if (rd_en) begin
                    n_iss = r_iss + 1'b1;
                end
                if (r_pend) begin
                    if (r_pidx == '0 || r_rd_stamp < r_best) begin
                        n_best      = r_rd_stamp;
                        n_vict_idx  = r_pidx;
                        n_vict_page = r_rd_page;
                    end
                    if (r_req.cls == lpcd_pkg::REQ_LOOKUP && !r_found
                            && r_rd_page == r_req.page) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_pidx;
                    end
                end
                if (!rd_en && !r_pend) begin
                    n_state = lpcd_pkg::BK_DECIDE;
                end
            end
            lpcd_pkg::BK_DECIDE: begin
                if (r_req.cls == lpcd_pkg::REQ_LOOKUP && r_found) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_hit_idx;
                    n_stamp      = r_stamp + 1'b1;
                    n_res_status = lpcd_pkg::ST_HIT;
                    n_res_slot   = r_hit_idx;
                    n_state      = lpcd_pkg::BK_RESULT;
                end else if (!r_req.ok) begin
                    n_res_status = lpcd_pkg::ST_FAILED;
                    n_state      = lpcd_pkg::BK_RESULT;
                end else if (full) begin
                    n_res_evicted = 1'b1;
                    n_res_evp     = r_vict_page;
                    n_count       = r_count - 1'b1;
                    n_iss         = CNT_W'(r_vict_idx) + 1'b1;
                    n_state       = lpcd_pkg::BK_SHIFT;
                end else begin
                    n_state = lpcd_pkg::BK_APPEND;
                end
            end
            lpcd_pkg::BK_SHIFT: begin
                // move entries above the victim down by one
                rd_en  = (r_iss <= r_count);
                n_pend = rd_en;
                n_pidx = r_iss[IDX_W-1:0];
                if (rd_en) begin
                    n_iss = r_iss + 1'b1;
                end
                if (r_pend) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_pidx - 1'b1;
                    wr_page  = r_rd_page;
                    wr_stamp = r_rd_stamp;
                end
                if (!rd_en && !r_pend) begin
                    n_state = lpcd_pkg::BK_APPEND;
                end
            end
            lpcd_pkg::BK_APPEND: begin
                wr_en        = 1'b1;
                wr_addr      = r_count[IDX_W-1:0];
                n_stamp      = r_stamp + 1'b1;
                n_count      = r_count + 1'b1;
                n_res_status = lpcd_pkg::ST_LOADED;
                n_res_slot   = r_count[IDX_W-1:0];
                n_state      = lpcd_pkg::BK_RESULT;
            end
            lpcd_pkg::BK_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tuser = r_res_status;
                    n_out_tdata = {occ_ext[lpcd_pkg::OCC_W-1:0], r_res_evp, r_res_evicted,
                                   slot_ext[lpcd_pkg::SLOT_W-1:0]};
                    n_state     = lpcd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lpcd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpcd_pkg::BK_IDLE;
            r_count     <= '0;
            r_stamp     <= lpcd_pkg::STAMP_INIT;
            r_cap       <= lpcd_pkg::CAP_W'(lpcd_pkg::DEF_CAPACITY);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_stamp     <= n_stamp;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_iss         <= n_iss;
        r_pidx        <= n_pidx;
        r_found       <= n_found;
        r_hit_idx     <= n_hit_idx;
        r_vict_idx    <= n_vict_idx;
        r_best        <= n_best;
        r_vict_page   <= n_vict_page;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_res_evicted <= n_res_evicted;
        r_res_evp     <= n_res_evp;
        r_out_tdata   <= n_out_tdata;
        r_out_tuser   <= n_out_tuser;
    end

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_page  <= mem_page[rd_addr];
            r_rd_stamp <= mem_stamp[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_page[wr_addr]  <= wr_page;
            mem_stamp[wr_addr] <= wr_stamp;
        end
    end

endmodule

>>> bench/tb_top.sv
module tb_top;
    import lpcd_pkg::*;

    localparam int  DIR_ENTRIES = DEF_ENTRIES;
    localparam int  POOL_SIZE   = 10;
    localparam int  CYCLE_LIMIT = 600000;
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [PAGE_W-1:0]   evicted_page;
        logic [OCC_W-1:0]    occupancy;
    } t_dir_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;

    lru_page_cache_directory_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // directory copy kept by the bench
    logic [PAGE_W-1:0]  dir_page  [DIR_ENTRIES];
    logic [STAMP_W-1:0] dir_stamp [DIR_ENTRIES];
    int                 dir_count = 0;
    logic [STAMP_W-1:0] dir_clock = STAMP_INIT;
    logic [CAP_W-1:0]   dir_cap = CAP_W'(DEF_CAPACITY);

    t_dir_result        pending_results[$];
    logic [PAGE_W-1:0]  page_pool[POOL_SIZE];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic               ready_hold = 1'b0;
    t_dir_result        seen_result;
    t_dir_result        want_result;

    function automatic t_dir_result predict_directory(input logic kind,
                                                      input logic [PAGE_W-1:0] page,
                                                      input logic ok);
        t_dir_result       r;
        int                cap_eff;
        int                victim;
        logic [STAMP_W-1:0] oldest;
        bit                done;
        r = '0;
        r.status = ST_FAILED;
        done = 1'b0;
        if (kind == KIND_LOOKUP && page == '0) begin
            r.status = ST_INVALID;
            done = 1'b1;
        end
        if (!done && kind == KIND_LOOKUP) begin
            for (int i = 0; i < dir_count; i++) begin
                if (dir_page[i] == page) begin
                    dir_stamp[i] = dir_clock;
                    dir_clock = dir_clock + 1'b1;
                    r.status = ST_HIT;
                    r.slot = SLOT_W'(i);
                    done = 1'b1;
                    break;
                end
            end
        end
        if (!done && ok) begin
            cap_eff = (dir_cap == '0) ? DEF_CAPACITY : int'(dir_cap);
            if (cap_eff > DIR_ENTRIES) cap_eff = DIR_ENTRIES;
            if (dir_count >= cap_eff && dir_count > 0) begin
                victim = 0;
                oldest = dir_stamp[0];
                for (int i = 1; i < dir_count; i++) begin
                    if (dir_stamp[i] < oldest) begin
                        oldest = dir_stamp[i];
                        victim = i;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = dir_page[victim];
                for (int i = victim; i + 1 < dir_count; i++) begin
                    dir_page[i] = dir_page[i + 1];
                    dir_stamp[i] = dir_stamp[i + 1];
                end
                dir_count--;
            end
            if (dir_count < DIR_ENTRIES) begin
                r.slot = SLOT_W'(dir_count);
                dir_page[dir_count] = page;
                dir_stamp[dir_count] = dir_clock;
                dir_clock = dir_clock + 1'b1;
                dir_count++;
            end
            r.status = ST_LOADED;
        end
        r.occupancy = OCC_W'(dir_count);
        return r;
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        if (ready_hold) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_result.status       = o_m_axis_tuser;
            seen_result.slot         = o_m_axis_tdata[2:0];
            seen_result.evicted      = o_m_axis_tdata[3];
            seen_result.evicted_page = o_m_axis_tdata[35:4];
            seen_result.occupancy    = o_m_axis_tdata[39:36];
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display({"unexpected result transfer: ",
                              "status %0d slot %0d ev %0b page %h occ %0d"},
                             seen_result.status, seen_result.slot, seen_result.evicted,
                             seen_result.evicted_page, seen_result.occupancy);
                end
                mismatch_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result) begin
                    if (mismatch_count < 10) begin
                        $display({"result differs: expected ",
                                  "status %0d slot %0d ev %0b page %h occ %0d"},
                                 want_result.status, want_result.slot, want_result.evicted,
                                 want_result.evicted_page, want_result.occupancy);
                        $display({"                got      ",
                                  "status %0d slot %0d ev %0b page %h occ %0d"},
                                 seen_result.status, seen_result.slot, seen_result.evicted,
                                 seen_result.evicted_page, seen_result.occupancy);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_page_cache_directory_unit: mismatch");
            $finish;
        end
    end

    task automatic send_req(input logic kind, input logic [PAGE_W-1:0] page, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {7'd0, ok, page};
        pending_results.push_back(predict_directory(kind, page, ok));
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random_req();
        logic              kind;
        logic [PAGE_W-1:0] page;
        logic              ok;
        int                r;
        r = $urandom_range(99);
        kind = ($urandom_range(99) < 40);
        if (r < 6) page = '0;
        else if (r < 16) page = $urandom;
        else page = page_pool[$urandom_range(POOL_SIZE - 1)];
        ok = ($urandom_range(99) < 85);
        send_req(kind, page, ok);
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = $urandom;
        if ($urandom_range(1)) page_pool[0] = '1;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dir_cap = cap;
    endtask

    task automatic run_random(input logic [CAP_W-1:0] cap, input int n);
        set_capacity(cap);
        refill_pool();
        repeat (n) send_random_req();
    endtask

    task automatic hold_receiver(input int n);
        fork
            begin
                ready_hold <= 1'b1;
                repeat (n) @(posedge i_clk);
                ready_hold <= 1'b0;
            end
        join_none
    endtask

    task automatic test_directed_cases();
        logic [PAGE_W-1:0] fill_ids[6];
        fill_ids = '{32'hA5A5A5A5, 32'h5A5A5A5A, 32'h1, 32'h2, 32'h3, 32'h4};
        send_idle_pct = 23;
        recv_idle_pct <= 45;
        // reset capacity of two
        send_req(KIND_LOOKUP, 32'h0, 1'b1);
        send_req(KIND_LOOKUP, 32'h0, 1'b0);
        send_req(KIND_LOOKUP, 32'hFFFFFFFF, 1'b0);
        send_req(KIND_INSERT, 32'h5, 1'b0);
        send_req(KIND_LOOKUP, 32'hFFFFFFFF, 1'b1);
        send_req(KIND_INSERT, 32'h0, 1'b1);
        send_req(KIND_LOOKUP, 32'hFFFFFFFF, 1'b0);
        send_req(KIND_LOOKUP, 32'h1234, 1'b1);
        send_req(KIND_INSERT, 32'h1234, 1'b1);
        send_req(KIND_LOOKUP, 32'h1234, 1'b0);
        set_capacity(4'd8);
        foreach (fill_ids[i]) send_req(KIND_INSERT, fill_ids[i], 1'b1);
        send_req(KIND_LOOKUP, 32'h5A5A5A5A, 1'b1);
        send_req(KIND_INSERT, 32'hDEAD0000, 1'b1);
        // capacity below occupancy
        set_capacity(4'd1);
        send_req(KIND_INSERT, 32'h9, 1'b1);
        send_req(KIND_LOOKUP, 32'hA, 1'b1);
        send_req(KIND_LOOKUP, 32'hA, 1'b0);
        set_capacity(4'd15);
        send_req(KIND_INSERT, 32'h0, 1'b1);
    endtask

    task automatic test_capacity_sweep();
        logic [CAP_W-1:0] caps[6];
        caps = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd9};
        send_idle_pct = 23;
        recv_idle_pct <= 45;
        foreach (caps[i]) run_random(caps[i], 140);
    endtask

    task automatic test_swapped_idling();
        logic [CAP_W-1:0] caps[4];
        caps = '{4'd5, 4'd2, 4'd7, 4'd12};
        send_idle_pct = 45;
        recv_idle_pct <= 23;
        foreach (caps[i]) run_random(caps[i], 130);
    endtask

    task automatic test_no_idling();
        logic [CAP_W-1:0] caps[3];
        caps = '{4'd8, 4'd4, 4'd6};
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        foreach (caps[i]) run_random(caps[i], 150);
    endtask

    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_capacity(4'd8);
        refill_pool();
        hold_receiver(300);
        repeat (40) send_random_req();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_capacity(4'd1);
        refill_pool();
        repeat (30) send_random_req();
        wait_drained();
        repeat (30) send_random_req();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_capacity_sweep();
        test_swapped_idling();
        test_no_idling();
        test_backpressure_fill();
        test_drain_pause();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("lru_page_cache_directory_unit: match");
        end else begin
            $display("lru_page_cache_directory_unit: mismatch");
        end
        $finish;
    end
endmodule
